### rtl/set_assoc_cache_tag_controller_assert.svh
// assertion macros for the cache tag controller
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SACTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SACTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sactc_pkg.sv
package sactc_pkg;

  localparam int unsigned MaxWays   = 8;
  localparam int unsigned MaxSets   = 64;
  localparam int unsigned CountBits = 16;
  localparam int unsigned WayBits   = 3;
  localparam int unsigned SetBits   = 6;
  localparam int unsigned Depth     = MaxWays * MaxSets;
  localparam int unsigned AddrBits  = 9;

  localparam logic [1:0] RegTotalLines = 2'd0;
  localparam logic [1:0] RegWays       = 2'd1;
  localparam logic [1:0] RegLineBytes  = 2'd2;

  typedef enum logic [9:0] {
    StClear = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StDiv1  = 10'b0000000100,
    StDiv2  = 10'b0000001000,
    StDiv3  = 10'b0000010000,
    StRead  = 10'b0000100000,
    StScan  = 10'b0001000000,
    StWrite = 10'b0010000000,
    StOut   = 10'b0100000000,
    StDiv0  = 10'b1000000000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_start;
    logic div_sel;      // 0 address by line size, 1 block by set count
    logic split1;
    logic split2;
    logic rd_issue;
    logic scan_step;
    logic commit;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic scan_last;
    logic nsets_done;
  } stat_t;

endpackage

### rtl/sactc_div.sv
module sactc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic [31:0] q_q, q_d, r_q, r_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {r_q, q_q[31]} - {1'b0, divisor_i};
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[30:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = q_d;
  assign rem_o  = r_d;

endmodule

### rtl/sactc_datapath.sv
`include "set_assoc_cache_tag_controller_assert.svh"

module sactc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sactc_pkg::cmd_t   cmd_i,
  output sactc_pkg::stat_t  stat_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [12:0]       cfg_data_i,
  input  logic              act_i,
  input  logic [31:0]       addr_i,
  output logic [85:0]       res_o,
  output logic              res_hit_o,
  output logic              res_ref_o
);

  localparam int unsigned CB = sactc_pkg::CountBits;
  localparam int unsigned WB = sactc_pkg::WayBits;
  localparam int unsigned SB = sactc_pkg::SetBits;
  localparam int unsigned AB = sactc_pkg::AddrBits;

  logic [9:0]  tl_q;
  logic [3:0]  wy_q;
  logic [12:0] lb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q <= 10'd64;
      wy_q <= 4'd2;
      lb_q <= 13'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sactc_pkg::RegTotalLines: tl_q <= cfg_data_i[9:0];
        sactc_pkg::RegWays:       wy_q <= cfg_data_i[3:0];
        sactc_pkg::RegLineBytes:  lb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0]  nw;
  logic [12:0] lb;
  always_comb begin
    nw = (wy_q == 4'd0) ? 4'd1 : ((wy_q > 4'd8) ? 4'd8 : wy_q);
    lb = (lb_q == 13'd0) ? 13'd1 : ((lb_q > 13'd4096) ? 13'd4096 : lb_q);
  end

  // set count by repeated subtraction of the way count
  logic [9:0] ns_rem_q, ns_rem_d;
  logic [9:0] ns_q, ns_d;
  logic [6:0] nsets;
  always_comb begin
    ns_rem_d = ns_rem_q;
    ns_d     = ns_q;
    if (cmd_i.load) begin
      ns_rem_d = tl_q;
      ns_d     = '0;
    end else if (ns_rem_q >= {6'd0, nw}) begin
      ns_rem_d = ns_rem_q - {6'd0, nw};
      ns_d     = ns_q + 10'd1;
    end
  end
  assign nsets = (ns_q == 10'd0) ? 7'd1 : ((ns_q > 10'd64) ? 7'd64 : ns_q[6:0]);

  logic        act_q;
  logic [31:0] addr_q, tag_q, blk_q;
  logic [11:0] off_q;
  logic [SB-1:0] set_q;

  logic        dv_done;
  logic [31:0] dv_q, dv_r;
  sactc_div u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(cmd_i.div_sel ? blk_q : addr_q),
    .divisor_i (cmd_i.div_sel ? {25'd0, nsets} : {19'd0, lb}),
    .done_o    (dv_done),
    .quot_o    (dv_q),
    .rem_o     (dv_r)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= act_i;
      addr_q <= addr_i;
    end
    if (cmd_i.split1) begin
      off_q <= dv_r[11:0];
      blk_q <= dv_q;
    end
    if (cmd_i.split2) begin
      set_q <= dv_r[SB-1:0];
      tag_q <= dv_q;
    end
  end

  // tag, count and dirty memory, one word per entry
  logic [32+CB:0] mem [sactc_pkg::Depth];
  logic [32+CB:0] rd_q, wr_data;
  logic [AB-1:0]  rd_addr, wr_addr, clr_q;
  logic           wr_en;
  logic [WB-1:0]  way_q;
  logic [3:0]     wcnt_q;

  assign rd_addr = {way_q, set_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_issue || cmd_i.scan_step) rd_q <= mem[rd_addr];
  end

  // scan state
  logic          found_q, empty_q;
  logic [WB-1:0] pick_q;
  logic [CB-1:0] best_q, pick_cnt_q;
  logic          pick_dirty_q;
  logic [CB-1:0] rc;
  logic [31:0]   rt;
  logic          rdy;
  assign rc  = rd_q[CB:1];
  assign rt  = rd_q[32+CB:CB+1];
  assign rdy = rd_q[0];

  logic [WB-1:0] cur_way_q;
  logic          first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      way_q <= '0;
      wcnt_q <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + AB'(1);
      if (cmd_i.load) begin
        way_q  <= '0;
        wcnt_q <= '0;
      end else if (cmd_i.rd_issue || cmd_i.scan_step) begin
        way_q  <= way_q + WB'(1);
        wcnt_q <= wcnt_q + 4'd1;
      end
    end
  end

  // the scan step evaluates the word read for cur_way_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      cur_way_q <= way_q;
      first_q   <= 1'b1;
      found_q   <= 1'b0;
      empty_q   <= 1'b0;
    end else if (cmd_i.scan_step || (cmd_i.commit && !first_q)) begin
      cur_way_q <= way_q;
      first_q   <= 1'b0;
    end
    if (cmd_i.scan_step || cmd_i.commit) begin
      if (!found_q && (rc != '0) && (rt == tag_q)) begin
        found_q <= 1'b1;
        pick_q <= cur_way_q; pick_cnt_q <= rc; pick_dirty_q <= rdy;
      end else if (!found_q && !empty_q && (rc == '0)) begin
        empty_q <= 1'b1;
        pick_q <= cur_way_q; pick_cnt_q <= rc; pick_dirty_q <= rdy;
      end else if (!found_q && !empty_q && (first_q || rc < best_q)) begin
        pick_q <= cur_way_q; pick_cnt_q <= rc; pick_dirty_q <= rdy;
      end
      if (first_q || rc < best_q) best_q <= rc;
    end
  end

  // final decision uses registers after the last scan evaluation
  logic [CB-1:0] bump;
  assign bump = (pick_cnt_q == {CB{1'b1}}) ? pick_cnt_q : pick_cnt_q + CB'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {pick_q, set_q};
    wr_data = {tag_q, bump, act_q};
    if (cmd_i.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (cmd_i.out_load) begin
      wr_en = 1'b1;
      if (found_q) wr_data = {tag_q, bump, act_q | pick_dirty_q};
    end
  end

  // result register, kept while the next item is worked on
  logic [85:0] res_q;
  logic        hit_q, ref_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q <= {off_q, 3'd0, set_q, tag_q, addr_q, act_q};
      hit_q <= found_q;
      ref_q <= found_q ? 1'b0 : (empty_q ? !act_q : (act_q ? pick_dirty_q : 1'b1));
    end
  end
  assign res_o     = res_q;
  assign res_hit_o = hit_q;
  assign res_ref_o = ref_q;

  // set count is final once the rest is below the way count or the clamp is reached
  assign stat_o.clr_done   = (clr_q == {AB{1'b1}});
  assign stat_o.div_done   = dv_done;
  assign stat_o.scan_last  = (wcnt_q == nw);
  assign stat_o.nsets_done = (ns_rem_q < {6'd0, nw}) || (ns_q >= 10'd64);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_rem_q <= '0;
      ns_q     <= '0;
    end else begin
      ns_rem_q <= ns_rem_d;
      ns_q     <= ns_d;
    end
  end

  `SACTC_ASSERT_IMP(a_clr_excl, cmd_i.clr_step, !cmd_i.out_load, "clear during update")
  `SACTC_ASSERT_NXT(a_scan_reset, cmd_i.load, way_q == '0, "way counter not reset")
  `SACTC_ASSERT_IMP(a_pick_range, cmd_i.out_load, {1'b0, pick_q} < nw, "victim beyond ways")

endmodule

### rtl/sactc_ctrl.sv
`include "set_assoc_cache_tag_controller_assert.svh"

module sactc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sactc_pkg::stat_t  stat_i,
  output sactc_pkg::cmd_t   cmd_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  sactc_pkg::state_e st_q, st_d;
  logic ov_q, ov_d;

  always_comb begin
    st_d  = st_q;
    ov_d  = ov_q && !out_ready_i;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      sactc_pkg::StClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) st_d = sactc_pkg::StIdle;
      end
      sactc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = sactc_pkg::StDiv0;
        end
      end
      sactc_pkg::StDiv0: begin
        cmd_o.div_start = 1'b1;
        st_d = sactc_pkg::StDiv1;
      end
      sactc_pkg::StDiv1: begin
        if (stat_i.div_done) begin
          cmd_o.split1 = 1'b1;
          st_d = sactc_pkg::StDiv2;
        end
      end
      sactc_pkg::StDiv2: begin
        if (stat_i.nsets_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          st_d = sactc_pkg::StDiv3;
        end
      end
      sactc_pkg::StDiv3: begin
        cmd_o.div_sel = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.split2 = 1'b1;
          st_d = sactc_pkg::StRead;
        end
      end
      sactc_pkg::StRead: begin
        cmd_o.rd_issue = 1'b1;
        st_d = sactc_pkg::StScan;
      end
      sactc_pkg::StScan: begin
        if (stat_i.scan_last) begin
          cmd_o.commit = 1'b1;
          st_d = sactc_pkg::StWrite;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      sactc_pkg::StWrite: begin
        if (!ov_q) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          st_d = sactc_pkg::StIdle;
        end
      end
      default: st_d = sactc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sactc_pkg::StClear;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  `SACTC_ASSERT_IMP(a_no_overwrite, cmd_o.out_load, !ov_q, "result overwritten")
  `SACTC_ASSERT_NXT(a_load_leaves, cmd_o.load, st_q == sactc_pkg::StDiv0, "load not followed")
  `SACTC_ASSERT_IMP(a_ready_idle, in_ready_o, st_q == sactc_pkg::StIdle, "ready outside idle")

endmodule

### rtl/set_assoc_cache_tag_controller.sv
// cache tag controller: after reset a clearing pass writes each of the 512 entries of the tag memory
// (tag, use count and dirty mark per entry) while no item is taken. an item then passes through
// a restoring division of the address by the line size, a wait for the set count (counted out
// of the line total, overlapping the first division), a restoring division of the block by the
// set count, one memory read per way of the set (up to eight) and one write back. the write back
// waits while the previous result is still unread. lookups find the first valid way holding the
// tag; a miss fills the first empty way or evicts the least used one. a finished result waits in
// the output register while the next item is already taken in
module set_assoc_cache_tag_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // address
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // address_echo, hit, mem_ref, line_tag, set_index, line_offset
  output logic        m_axis_tuser,  // was_write
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  sactc_pkg::cmd_t  cmd;
  sactc_pkg::stat_t stat;
  logic [85:0] res;
  logic        hit, mref;

  sactc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  sactc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .act_i      (s_axis_tuser),
    .addr_i     (s_axis_tdata),
    .res_o      (res),
    .res_hit_o  (hit),
    .res_ref_o  (mref)
  );

  // res: kind[0], addr[32:1], tag[64:33], set[73:65], off[85:74]
  assign m_axis_tdata = {1'b0, res[85:74], res[73:65], res[64:33], mref, hit, res[32:1]};
  assign m_axis_tuser = res[0];

endmodule

### dv/cache_tag_checker.sv
module cache_tag_checker (
  input  logic        clk_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // laid out as {tuser, tdata[86:0]}
  typedef struct packed {
    logic        was_write;
    logic [11:0] line_offset;
    logic [8:0]  set_index;
    logic [31:0] line_tag;
    logic        mem_ref;
    logic        hit;
    logic [31:0] address_echo;
  } lookup_t;

  logic [9:0]  total_lines_q = 10'd64;
  logic [3:0]  ways_q        = 4'd2;
  logic [12:0] line_bytes_q  = 13'd16;

  logic [31:0]                     tag_mem   [sactc_pkg::Depth];
  logic [sactc_pkg::CountBits-1:0] count_mem [sactc_pkg::Depth];
  logic                            dirty_mem [sactc_pkg::Depth];

  lookup_t lookup_q[$];
  int      errors = 0;

  initial begin
    for (int e = 0; e < sactc_pkg::Depth; e++) begin
      tag_mem[e]   = '0;
      count_mem[e] = '0;
      dirty_mem[e] = 1'b0;
    end
  end

  assign errors_o  = errors;
  assign pending_o = lookup_q.size();

  function automatic logic [sactc_pkg::CountBits-1:0] bump(
      logic [sactc_pkg::CountBits-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // tag lookup and replacement, updates the shadow store
  function automatic lookup_t lookup(logic is_wr, logic [31:0] addr);
    lookup_t r;
    int unsigned nw, lb, ns, blk, set, e, pick;
    logic found, empty;
    logic [sactc_pkg::CountBits-1:0] best;
    nw = ways_q;
    if (nw == 0) nw = 1;
    if (nw > sactc_pkg::MaxWays) nw = sactc_pkg::MaxWays;
    lb = line_bytes_q;
    if (lb == 0) lb = 1;
    if (lb > 4096) lb = 4096;
    ns = total_lines_q / nw;
    if (ns == 0) ns = 1;
    if (ns > sactc_pkg::MaxSets) ns = sactc_pkg::MaxSets;
    blk = addr / lb;
    set = blk % ns;
    r.was_write    = is_wr;
    r.address_echo = addr;
    r.line_offset  = 12'(addr % lb);
    r.set_index    = 9'(set);
    r.line_tag     = blk / ns;
    r.hit          = 1'b0;
    r.mem_ref      = 1'b0;
    found = 1'b0;
    pick  = set;
    for (int w = 0; w < nw && !found; w++) begin
      e = w * sactc_pkg::MaxSets + set;
      if (count_mem[e] != 0 && tag_mem[e] == r.line_tag) begin
        found = 1'b1;
        pick  = e;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      count_mem[pick] = bump(count_mem[pick]);
      if (is_wr) dirty_mem[pick] = 1'b1;
    end else begin
      empty = 1'b0;
      for (int w = 0; w < nw && !empty; w++) begin
        e = w * sactc_pkg::MaxSets + set;
        if (count_mem[e] == 0) begin
          empty = 1'b1;
          pick  = e;
        end
      end
      if (empty) begin
        r.mem_ref = !is_wr;
      end else begin
        // least used way, lowest way wins ties
        pick = set;
        best = count_mem[set];
        for (int w = 1; w < nw; w++) begin
          e = w * sactc_pkg::MaxSets + set;
          if (count_mem[e] < best) begin
            best = count_mem[e];
            pick = e;
          end
        end
        r.mem_ref = is_wr ? dirty_mem[pick] : 1'b1;
      end
      count_mem[pick] = bump(count_mem[pick]);
      tag_mem[pick]   = r.line_tag;
      dirty_mem[pick] = is_wr;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    lookup_t got, exp;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sactc_pkg::RegTotalLines: total_lines_q = cfg_data_i[9:0];
        sactc_pkg::RegWays:       ways_q        = cfg_data_i[3:0];
        sactc_pkg::RegLineBytes:  line_bytes_q  = cfg_data_i;
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready)
      lookup_q.push_back(lookup(s_axis_tuser, s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[86:0]};
      if (lookup_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp = lookup_q.pop_front();
        if (got.was_write !== exp.was_write || got.address_echo !== exp.address_echo ||
            got.hit !== exp.hit || got.mem_ref !== exp.mem_ref ||
            got.line_tag !== exp.line_tag || got.set_index !== exp.set_index ||
            got.line_offset !== exp.line_offset || m_axis_tdata[87] !== 1'b0) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch wr %b/%b addr %h/%h hit %b/%b mref %b/%b ",
                      "tag %h/%h set %0d/%0d off %0d/%0d"},
                     exp.was_write, got.was_write, exp.address_echo, got.address_echo,
                     exp.hit, got.hit, exp.mem_ref, got.mem_ref,
                     exp.line_tag, got.line_tag, exp.set_index, got.set_index,
                     exp.line_offset, got.line_offset);
        end
      end
    end
  end
endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it
  localparam logic [1:0] RegSpare = 2'd3;
  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // address
  logic        s_axis_tuser = 1'b0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;  // address_echo, hit, mem_ref, line_tag, set_index, line_offset
  logic        m_axis_tuser;  // was_write
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;

  int errors, pending;
  int idle_cycles = 0;
  int stall_mode = 1;  // 0 never stall, 1 light, 2 heavy
  logic [31:0] addr_pool[24];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  set_assoc_cache_tag_controller dut (.*);

  cache_tag_checker u_checker (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  // random back pressure on the result side
  always @(posedge clk_i) begin
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // gaps: mostly none or short, now and then long
  function automatic int pick_gap();
    if (stall_mode == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 2);
  endfunction

  // one access, holds valid until the block takes it
  task automatic send_access(logic is_wr, logic [31:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= is_wr;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // block is idle once every result is back, then program the geometry
  task automatic set_geometry(logic [12:0] lines, logic [12:0] nways, logic [12:0] lbytes);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sactc_pkg::RegTotalLines;
    cfg_data_i <= lines;
    @(posedge clk_i);
    cfg_idx_i <= sactc_pkg::RegWays;
    cfg_data_i <= nways;
    @(posedge clk_i);
    cfg_idx_i <= sactc_pkg::RegLineBytes;
    cfg_data_i <= lbytes;
    @(posedge clk_i);
    cfg_idx_i <= RegSpare;
    cfg_data_i <= 13'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly reuse of a small line pool so hits and evictions happen, rest full random
  task automatic random_phase(int count);
    logic [31:0] a;
    for (int i = 0; i < 24; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < 24; i++)
      if (i % 3 == 0) addr_pool[i] = addr_pool[0] ^ (32'($urandom_range(0, 7)) << $urandom_range(4, 14));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 4) == 0) a = $urandom;
      else a = addr_pool[$urandom_range(0, 23)] ^ 32'($urandom_range(0, 3));
      send_access(1'($urandom_range(0, 1)), a);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed with the reset geometry: 32 sets of 2 ways, 16-byte lines
    stall_mode = 0;
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h0000_0000);   // hit, marks dirty
    send_access(1'b0, 32'h0000_0004);   // hit
    send_access(1'b1, 32'h0000_0200);   // fills second way
    send_access(1'b0, 32'h0000_0400);   // read miss evicts least used
    send_access(1'b1, 32'h0000_0600);   // write miss evicts a clean line
    send_access(1'b1, 32'h0000_0800);   // write miss evicts a dirty line
    send_access(1'b0, 32'h0000_0800);
    send_access(1'b0, 32'hFFFF_FFF0);

    // degenerate geometry: zero ways, zero lines, zero line size
    set_geometry(13'd0, 13'd0, 13'd0);
    send_access(1'b1, 32'h0000_0001);
    send_access(1'b0, 32'h0000_0001);
    send_access(1'b0, 32'h8000_0000);
    // oversized everything, sets clamp to the maximum
    set_geometry(13'h1FFF, 13'hF, 13'h1FFF);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h0000_0FFF);
    send_access(1'b0, 32'h0000_1000);
    // fewer lines than ways, stored lines read under a new geometry
    set_geometry(13'd3, 13'd8, 13'd4096);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'h0000_1000);

    stall_mode = 1;
    set_geometry(13'd64, 13'd2, 13'd16);
    random_phase(250);
    set_geometry(13'd512, 13'd8, 13'd4096);
    random_phase(250);
    set_geometry(13'd1, 13'd1, 13'd1);
    random_phase(250);
    set_geometry(13'd16, 13'd4, 13'd8);
    random_phase(250);
    set_geometry(13'd0, 13'd0, 13'd0);
    random_phase(150);
    set_geometry(13'h3FF, 13'hF, 13'h1FFF);
    random_phase(200);
    for (int p = 0; p < 4; p++) begin
      set_geometry(13'($urandom_range(0, 1023)), 13'($urandom_range(0, 15)),
                   13'($urandom_range(0, 8191)));
      random_phase(100);
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
